// ===== rtl/bssc_pkg.sv =====
// ============================================================================
// bssc_pkg
// Shared constants, widths and modular helpers of the bounded step
// sequence counter.
// ============================================================================
package bssc_pkg;

    localparam int MAX_VALUE = 128;

    localparam int COUNT_W  = 30;
    localparam int ENTRY_W  = 8;
    localparam int SLOT_W   = $clog2(MAX_VALUE);
    localparam int CNT_W    = $clog2(MAX_VALUE + 2);
    localparam int VAL_W    = ($clog2(MAX_VALUE + 1) > ENTRY_W) ?
                              $clog2(MAX_VALUE + 1) : ENTRY_W;
    localparam int SUM_W    = COUNT_W + 2;

    localparam logic [SUM_W-1:0]   MODULUS    = SUM_W'(1000000007);
    localparam logic [SUM_W-1:0]   MODULUS_X2 = SUM_W'(2000000014);

    // a + b with both below the modulus
    function automatic logic [COUNT_W-1:0] add_mod2(
        input logic [COUNT_W-1:0] a,
        input logic [COUNT_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= MODULUS) begin
            s = s - MODULUS;
        end
        return s[COUNT_W-1:0];
    endfunction

    // reduce a sum of up to three residues
    function automatic logic [COUNT_W-1:0] reduce3(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        if (s >= MODULUS_X2) begin
            r = s - MODULUS_X2;
        end else if (s >= MODULUS) begin
            r = s - MODULUS;
        end else begin
            r = s;
        end
        return r[COUNT_W-1:0];
    endfunction

endpackage

// ===== rtl/bssc_if.sv =====
// ============================================================================
// bssc channel interfaces
// Valid/ready channels for sequence entries, results and the bound register.
// ============================================================================
interface bssc_in_if;
    logic                           valid;
    logic                           ready;
    logic [bssc_pkg::ENTRY_W-1:0]   entry_value;
    logic                           last_entry;

    modport source (output valid, output entry_value, output last_entry, input ready);
    modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

interface bssc_out_if;
    logic                           valid;
    logic                           ready;
    logic [bssc_pkg::COUNT_W-1:0]   array_count;

    modport source (output valid, output array_count, input ready);
    modport sink   (input valid, input array_count, output ready);
endinterface

interface bssc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bssc_pkg::ENTRY_W-1:0]   max_value;

    modport source (output valid, output max_value, input ready);
    modport sink   (input valid, input max_value, output ready);
endinterface

// ===== rtl/bssc_ram.sv =====
// ============================================================================
// bssc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module bssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bounded_step_sequence_counter.sv =====
// ============================================================================
// bounded_step_sequence_counter
// Counts, mod 1000000007, arrays matching a partly known sequence with
// entries in 1..max_value and neighbor steps of at most one.
// ============================================================================
// Each item sweeps all MAX_VALUE count slots through the count RAM once,
// with one RAM read and one write per slot; no new item is accepted until
// the sweep, FINISH and DONE are through. A last item's result waits in an
// output register; a last item's DONE holds until that register is free.
// Reset: bound register = 1, next item starts a sequence; RAM not cleared.
module bounded_step_sequence_counter (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bssc_cfg_if.sink   i_cfg,
    bssc_in_if.sink    i_item,
    bssc_out_if.source o_result
);
    import bssc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_VALUE + 1);
    localparam logic [CNT_W-1:0] CNT_RD_LAST = CNT_W'(MAX_VALUE);

    logic [1:0]         r_state, n_state;
    logic [ENTRY_W-1:0] r_max_value;
    logic               r_first;
    logic [VAL_W-1:0]   r_entry;
    logic               r_last;
    logic [VAL_W-1:0]   r_bound;
    logic [CNT_W-1:0]   r_cnt;
    logic [COUNT_W-1:0] r_prev, r_cur;
    logic [COUNT_W-1:0] r_wval;
    logic               r_wv_en;
    logic [COUNT_W-1:0] r_acc;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    logic [COUNT_W-1:0] w_rdata;
    logic [COUNT_W-1:0] w_next;
    logic [SLOT_W-1:0]  w_slot;
    logic [VAL_W-1:0]   w_v;
    logic               w_allowed;
    logic               w_write;
    logic [SUM_W-1:0]   w_sum;
    logic [COUNT_W-1:0] w_new;
    logic               w_accept;
    logic               w_out_free;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == ST_IDLE);

    assign o_result.valid       = r_out_valid;
    assign o_result.array_count = r_out_count;

    // slot being written trails the read address by two
    assign w_slot  = SLOT_W'(r_cnt - CNT_W'(2));
    assign w_v     = VAL_W'(w_slot) + VAL_W'(1);
    assign w_write = (r_state == ST_SWEEP) && (r_cnt >= CNT_W'(2));

    // word past the top slot reads as zero
    assign w_next = (r_cnt <= CNT_RD_LAST) ? w_rdata : '0;

    assign w_allowed = (w_v <= r_bound) && ((r_entry == '0) || (r_entry == w_v));

    always_comb begin
        w_sum = SUM_W'(r_cur);
        if (w_slot != '0) begin
            w_sum = w_sum + SUM_W'(r_prev);
        end
        if (w_v < r_bound) begin
            w_sum = w_sum + SUM_W'(w_next);
        end
        if (!w_allowed) begin
            w_new = '0;
        end else if (r_first) begin
            w_new = COUNT_W'(1);
        end else begin
            w_new = reduce3(w_sum);
        end
    end

    bssc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_VALUE)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (w_slot),
        .i_wdata (w_new),
        .i_raddr (r_cnt[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == CNT_END) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_last || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_value <= ENTRY_W'(1);
            r_first     <= 1'b1;
            r_cnt       <= '0;
            r_wv_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_value <= i_cfg.max_value;
            end
            r_wv_en <= w_write;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_SWEEP) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == ST_DONE && n_state == ST_IDLE) begin
                r_first <= r_last;
            end
            if (r_state == ST_DONE && n_state == ST_IDLE && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= VAL_W'(i_item.entry_value);
            r_last  <= i_item.last_entry;
            if (VAL_W'(r_max_value) > VAL_W'(MAX_VALUE)) begin
                r_bound <= VAL_W'(MAX_VALUE);
            end else begin
                r_bound <= VAL_W'(r_max_value);
            end
            r_acc <= '0;
        end else if (r_wv_en) begin
            r_acc <= add_mod2(r_acc, r_wval);
        end
        if (r_state == ST_SWEEP && r_cnt != '0) begin
            r_prev <= r_cur;
            r_cur  <= w_next;
        end
        r_wval <= w_new;
        if (r_state == ST_DONE && n_state == ST_IDLE && r_last) begin
            r_out_count <= r_acc;
        end
    end

    // running total stays reduced
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH || r_state == ST_DONE) |-> (SUM_W'(r_acc) < MODULUS))
        else $error("running total not reduced");

    // a new result only comes from a finished last item
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE) && $past(r_last))
        else $error("result without finished last item");

    // the sweep never writes the slot it is reading
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && r_cnt < CNT_RD_LAST) |-> (w_slot != r_cnt[SLOT_W-1:0]))
        else $error("count RAM read/write collision");

    // every item is fully swept before the machine reports done
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> ($past(r_cnt) == CNT_END) && $past(r_wv_en))
        else $error("sweep ended early");
endmodule
